>>> rtl/core/vrfc_pkg.sv
// shared types and constants for the route feasibility checker
`timescale 1ns / 1ps

package vrfc_pkg;

  localparam int DEF_MAX_NODES = 256;
  localparam int EPOCH_W       = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEHICLES = 2'd2;

  localparam logic [8:0]  RST_NODE_COUNT   = 9'd256;
  localparam logic [23:0] RST_CAPACITY     = 24'hFFFFFF;
  localparam logic [7:0]  RST_MAX_VEHICLES = 8'd255;

  typedef enum logic [2:0] {
    FAIL_OK       = 3'd0,
    FAIL_SHORT    = 3'd1,
    FAIL_BADNODE  = 3'd2,
    FAIL_DUP      = 3'd3,
    FAIL_OVER     = 3'd4,
    FAIL_VEH      = 3'd5,
    FAIL_UNSERVED = 3'd6
  } fail_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } seq_state_t;

  typedef struct packed {
    logic [8:0]  node_count;
    logic [23:0] capacity;
    logic [7:0]  max_vehicles;
  } cfg_t;

  typedef struct packed {
    logic        last;
    logic [15:0] demand;
    logic [7:0]  node;
  } item_t;

  typedef struct packed {
    fail_t reason;
    logic  valid_res;
  } verdict_t;

endpackage

>>> rtl/core/vrfc_mark_mem.sv
// visited-mark memory: one write port, one registered read port
`timescale 1ns / 1ps

module vrfc_mark_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/vrfc_route_eval.sv
// per-solution running state and check logic for one item
`timescale 1ns / 1ps

module vrfc_route_eval import vrfc_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  item_t    item,
  input  logic     visited,
  input  cfg_t     cfg,
  output logic     mark_we,
  output verdict_t verdict
);

  logic [24:0] load, load_next;
  logic [8:0]  veh, veh_next;
  logic [8:0]  served, served_next;
  logic [1:0]  cnt, cnt_next;
  fail_t       fail, fail_next;

  logic [24:0] sum;
  logic [8:0]  needed;
  logic        bad_node;
  logic        new_mark;
  fail_t       reason;

  // numbers that do not fit the mark storage are rejected too
  assign bad_node = ({1'b0, item.node} >= cfg.node_count) ||
                    (32'(item.node) >= 32'(MAX_NODES));
  assign sum      = load + 25'(item.demand);
  assign needed   = (cfg.node_count == 9'd0) ? 9'd0 : cfg.node_count - 9'd1;

  always_comb begin
    load_next   = load;
    veh_next    = veh;
    served_next = served;
    fail_next   = fail;
    new_mark    = 1'b0;
    cnt_next    = (cnt == 2'd3) ? cnt : cnt + 2'd1;
    if (fail == FAIL_OK) begin
      if (item.node == 8'd0) begin
        if (load != 25'd0) begin
          veh_next  = (veh == 9'd511) ? veh : veh + 9'd1;
          load_next = 25'd0;
        end
      end else if (bad_node) begin
        fail_next = FAIL_BADNODE;
      end else if (visited) begin
        fail_next = FAIL_DUP;
      end else begin
        new_mark    = 1'b1;
        served_next = (served == 9'd511) ? served : served + 9'd1;
        load_next   = sum;
        if (sum > {1'b0, cfg.capacity}) begin
          fail_next = FAIL_OVER;
        end
      end
    end

    if (cnt_next != 2'd3) begin
      reason = FAIL_SHORT;
    end else if (fail_next != FAIL_OK) begin
      reason = fail_next;
    end else if (veh_next > {1'b0, cfg.max_vehicles}) begin
      reason = FAIL_VEH;
    end else if (served_next != needed) begin
      reason = FAIL_UNSERVED;
    end else begin
      reason = FAIL_OK;
    end
  end

  // the last item needs no mark: the solution ends with it
  assign mark_we           = fire && !item.last && new_mark;
  assign verdict.reason    = reason;
  assign verdict.valid_res = (reason == FAIL_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      load   <= '0;
      veh    <= '0;
      served <= '0;
      cnt    <= '0;
      fail   <= FAIL_OK;
    end else if (fire) begin
      if (item.last) begin
        load   <= '0;
        veh    <= '0;
        served <= '0;
        cnt    <= '0;
        fail   <= FAIL_OK;
      end else begin
        load   <= load_next;
        veh    <= veh_next;
        served <= served_next;
        cnt    <= cnt_next;
        fail   <= fail_next;
      end
    end
  end

endmodule

>>> rtl/core/vehicle_route_feasibility_check.sv
// Checks a vehicle-routing solution streamed one node per item.
// Input items arrive on s_axis: tdata carries node [7:0] and demand [23:8],
// tlast marks the final item of a solution. One verdict item per solution
// leaves on m_axis after the final item: tdata[0] valid_res, tdata[3:1]
// fail_reason. Registers node_count, capacity and max_vehicles are written on
// the cfg port (index 0, 1, 2); the user must write them only while the block
// is idle; the block does not enforce it. Throughput is one item per cycle
// while s_axis_tready is high. An item is checked the cycle after it is
// accepted, once its visited mark comes back from the mark memory; the verdict
// is registered before it shows on m_axis. Visited marks are stored as epoch
// numbers, so a new solution starts at once without clearing. After reset, and
// after every 255 solutions when the epoch wraps, a clearing pass writes every
// entry, one per cycle; s_axis_tready stays low meanwhile. A stalled verdict
// holds the pipeline only when the next final item reaches the check stage;
// other items keep flowing into the block.
`timescale 1ns / 1ps

module vehicle_route_feasibility_check import vrfc_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // node[7:0], demand[23:8]
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // valid_res[0], fail_reason[3:1]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_NODES - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  cfg_t cfg;

  seq_state_t        state, state_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [EPOCH_W-1:0] epoch;

  item_t    in_item, s1_item;
  logic     s1_valid, fwd;
  logic     s1_stall, s1_fire, wrap_hold, accept, clearing;
  logic     mark_we, visited;
  verdict_t verdict, out_verdict;
  logic     out_valid;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [EPOCH_W-1:0] mem_wdata, mem_rdata;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_count   <= RST_NODE_COUNT;
      cfg.capacity     <= RST_CAPACITY;
      cfg.max_vehicles <= RST_MAX_VEHICLES;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NODE_COUNT:   cfg.node_count   <= cfg_data[8:0];
        CFG_CAPACITY:     cfg.capacity     <= cfg_data;
        CFG_MAX_VEHICLES: cfg.max_vehicles <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // handshake and stage control
  assign in_item.node   = s_axis_tdata[7:0];
  assign in_item.demand = s_axis_tdata[23:8];
  assign in_item.last   = s_axis_tlast;

  assign clearing  = (state == ST_CLEAR);
  assign s1_stall  = s1_valid && s1_item.last && out_valid && !m_axis_tready;
  assign s1_fire   = s1_valid && !s1_stall;
  // a wrapping epoch needs the memory cleared before the next item is read
  assign wrap_hold = s1_valid && s1_item.last && (epoch == '1);
  assign s_axis_tready = !clearing && !s1_stall && !wrap_hold;
  assign accept    = s_axis_tvalid && s_axis_tready;

  // clearing sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    unique case (state)
      ST_CLEAR: begin
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == LAST_ADDR) begin
          state_next    = ST_RUN;
          clr_addr_next = '0;
        end
      end
      ST_RUN: begin
        if (s1_fire && s1_item.last && (epoch == '1)) begin
          state_next = ST_CLEAR;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= EPOCH_FIRST;
    end else if (s1_fire && s1_item.last) begin
      epoch <= (epoch == '1) ? EPOCH_FIRST : epoch + EPOCH_W'(1);
    end
  end

  // mark memory
  assign mem_we    = clearing || mark_we;
  assign mem_waddr = clearing ? clr_addr : ADDR_W'(s1_item.node);
  assign mem_wdata = clearing ? '0 : epoch;

  vrfc_mark_mem #(
    .DEPTH  (MAX_NODES),
    .ADDR_W (ADDR_W),
    .DATA_W (EPOCH_W)
  ) u_mark_mem (
    .clk   (clk),
    .re    (accept),
    .raddr (ADDR_W'(in_item.node)),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  // check stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || s1_stall;
    end
  end

  // forward a mark written in the same cycle the next item reads it
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
      fwd     <= mark_we && (mem_waddr == ADDR_W'(in_item.node));
    end
  end

  assign visited = fwd || (mem_rdata == epoch);

  vrfc_route_eval #(
    .MAX_NODES (MAX_NODES)
  ) u_route_eval (
    .clk     (clk),
    .rst     (rst),
    .fire    (s1_fire),
    .item    (s1_item),
    .visited (visited),
    .cfg     (cfg),
    .mark_we (mark_we),
    .verdict (verdict)
  );

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_item.last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.last) begin
      out_verdict <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_verdict.reason, out_verdict.valid_res};

endmodule

>>> rtl/core/vrfc_checker.sv
// port-level checks for the route feasibility checker, bound to the top level
`timescale 1ns / 1ps

module vrfc_checker import vrfc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a stalled verdict holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict changed while stalled");

  // pass flag agrees with the reason code
  a_pass_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == FAIL_OK)))
    else $error("valid_res disagrees with fail_reason");

  // a fresh verdict follows a final item taken through the check stage and the verdict register
  a_verdict_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("verdict without a final item");

  // mark clearing runs right after reset, so no item is taken
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("block active right after reset");

endmodule

bind vehicle_route_feasibility_check vrfc_checker u_vrfc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
